>>> sv/drive_wheel_mixer_core_assert.svh
// ---------------------------------------------------------------------------
// Drive wheel mixer assertion macros
// Short forms for the concurrent checks written at the end of the core module.
// ---------------------------------------------------------------------------
`ifndef DRIVE_WHEEL_MIXER_CORE_ASSERT_SVH
`define DRIVE_WHEEL_MIXER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DWM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dwm_pkg.sv
// ---------------------------------------------------------------------------
// Drive wheel mixer package
// Widths, codes and the word that travels down the divider pipeline.
// ---------------------------------------------------------------------------
package dwm_pkg;

  // Field widths.
  localparam int AXIS_W  = 8;
  localparam int SENS_W  = 16;
  localparam int DZ_W    = 7;
  localparam int WHEEL_W = 16;
  localparam int NAXES   = 3;
  localparam int LANES   = 4;

  // Internal widths: axis times gain, scaled axis, three-way sum, magnitude.
  localparam int PROD_W = AXIS_W + SENS_W + 1;
  localparam int SCL_W  = PROD_W - 4;
  localparam int SUM_W  = SCL_W + 1;
  localparam int MAG_W  = SCL_W;
  localparam int QUO_W  = 15;
  localparam int NUM_W  = MAG_W + QUO_W;

  // 100 percent in Q8.8.
  localparam int FULL_SCALE = 25600;

  // Register reset values.
  localparam logic [DZ_W-1:0]   DZ_RESET   = DZ_W'(5);
  localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(4096);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE    = 1'b0,
    REG_SENSITIVITY = 1'b1
  } cfg_reg_t;

  // Drive modes.
  typedef enum logic [1:0] {
    FUNC_ARCADE  = 2'd0,
    FUNC_TANK    = 2'd1,
    FUNC_MECANUM = 2'd2,
    FUNC_STOP    = 2'd3
  } func_t;

  // One wheel inside the divider pipeline.
  typedef struct packed {
    logic [NUM_W-1:0]   rem;
    logic [QUO_W-1:0]   quo;
    logic               neg;
    logic [WHEEL_W-1:0] direct;
  } lane_t;

  // One command inside the divider pipeline.
  typedef struct packed {
    logic                   valid;
    logic                   scale;
    logic                   brake;
    logic [MAG_W-1:0]       divisor;
    lane_t [LANES-1:0]      lane;
  } div_word_t;

endpackage

>>> sv/drive_wheel_mixer_core.sv
// ---------------------------------------------------------------------------
// Drive wheel mixer core
// Turns one drive command into four wheel velocities and a brake flag.
// ---------------------------------------------------------------------------
// Commands arrive on the s_ stream: s_tuser holds the mode and s_tdata the
// forward, turn and strafe axes in signed percent. Results leave on the m_
// stream: s_tdata-like packing of four signed Q8.8 wheel velocities in
// m_tdata and the brake flag in m_tuser. The cfg_ channel writes the
// deadzone (index 0) and the sensitivity (index 1); it is always ready and
// must only be used while no command is in flight.
// The pipeline has four stages for gain, mixing, peak search and numerator,
// fifteen stages of the restoring divider (one quotient bit each) and the
// output register. Throughput is one word per cycle while the receiver does
// not stall; the divider is fully pipelined.
// Reset clears all valid bits and loads deadzone 5 and sensitivity 1.0.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "drive_wheel_mixer_core_assert.svh"

module drive_wheel_mixer_core
  import dwm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Command stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [23:0]            s_tdata,   // forward_or_left, turn_or_right, strafe
  input  logic [1:0]             s_tuser,   // func
  // Wheel stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [63:0]            m_tdata,   // left_front, left_back, right_front, right_back
  output logic                   m_tuser,   // brake
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SENS_W-1:0]      cfg_data
);

  localparam logic signed [SUM_W-1:0]   FS_SUM   = SUM_W'(FULL_SCALE);
  localparam logic [MAG_W-1:0]          FS_MAG   = MAG_W'(FULL_SCALE);
  localparam logic [NUM_W-1:0]          FS_NUM   = NUM_W'(FULL_SCALE);
  localparam logic [QUO_W-1:0]          FS_QUO   = QUO_W'(FULL_SCALE);
  localparam logic signed [WHEEL_W-1:0] FS_WHEEL = WHEEL_W'(FULL_SCALE);

  logic                   en;
  logic [DZ_W-1:0]        deadzone;
  logic [SENS_W-1:0]      sensitivity;

  logic signed [AXIS_W-1:0] axis     [NAXES];
  logic [AXIS_W-1:0]        axis_mag [NAXES];
  logic signed [PROD_W-1:0] ax_ext   [NAXES];
  logic signed [PROD_W-1:0] sens_ext;
  logic signed [PROD_W-1:0] prod     [NAXES];

  logic                     s1_valid;
  func_t                    s1_func;
  logic signed [PROD_W-1:0] s1_prod [NAXES];
  logic                     s1_zero [NAXES];

  logic signed [SCL_W-1:0]  scaled [NAXES];
  logic signed [SUM_W-1:0]  f_ax, t_ax, s_ax;
  logic signed [SUM_W-1:0]  w_next [LANES];
  logic                     brake_next;
  logic                     mec_next;

  logic                     s2_valid;
  logic                     s2_mec;
  logic                     s2_brake;
  logic signed [SUM_W-1:0]  s2_w [LANES];

  logic [MAG_W-1:0]         w_mag [LANES];
  logic [MAG_W-1:0]         max01, max23, max_all;

  logic                     s3_valid;
  logic                     s3_scale;
  logic                     s3_brake;
  logic [MAG_W-1:0]         s3_max;
  logic [MAG_W-1:0]         s3_mag    [LANES];
  logic                     s3_neg    [LANES];
  logic [WHEEL_W-1:0]       s3_direct [LANES];

  div_word_t                d0_next;
  div_word_t                div_pipe [QUO_W+1];
  div_word_t                div_out;

  logic [WHEEL_W-1:0]       q_ext   [LANES];
  logic [WHEEL_W-1:0]       wheel_next [LANES];
  logic [WHEEL_W-1:0]       out_w   [LANES];
  logic                     out_brake;
  logic [LANES-1:0]         out_ok;
  logic [LANES-1:0]         quo_ok;

  // The pipeline moves whenever the output register is free or being taken.
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone    <= DZ_RESET;
      sensitivity <= SENS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEADZONE:    deadzone    <= cfg_data[DZ_W-1:0];
        REG_SENSITIVITY: sensitivity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: deadzone test and axis times gain.
  assign sens_ext = $signed(PROD_W'({1'b0, sensitivity}));
  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      axis[i]     = $signed(s_tdata[i*AXIS_W +: AXIS_W]);
      axis_mag[i] = axis[i][AXIS_W-1] ? AXIS_W'(-axis[i]) : AXIS_W'(axis[i]);
      ax_ext[i]   = PROD_W'(axis[i]);
      prod[i]     = ax_ext[i] * sens_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
      s1_func  <= func_t'(s_tuser);
      for (int i = 0; i < NAXES; i++) begin
        s1_prod[i] <= prod[i];
        s1_zero[i] <= axis_mag[i] < AXIS_W'(deadzone);
      end
    end
  end

  // Clamp a side to plus or minus full scale.
  function automatic logic signed [SUM_W-1:0] clamp_fs(input logic signed [SUM_W-1:0] v);
    if (v > FS_SUM) begin
      clamp_fs = FS_SUM;
    end else if (v < -FS_SUM) begin
      clamp_fs = -FS_SUM;
    end else begin
      clamp_fs = v;
    end
  endfunction

  // Stage 2: shift into Q8.8 (floor) and mix according to the mode.
  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      scaled[i] = s1_zero[i] ? '0 : $signed(s1_prod[i][PROD_W-1:4]);
    end
    f_ax       = SUM_W'(scaled[0]);
    t_ax       = SUM_W'(scaled[1]);
    s_ax       = SUM_W'(scaled[2]);
    brake_next = 1'b0;
    mec_next   = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      w_next[i] = '0;
    end
    case (s1_func)
      FUNC_ARCADE: begin
        w_next[0] = clamp_fs(f_ax + t_ax);
        w_next[1] = w_next[0];
        w_next[2] = clamp_fs(f_ax - t_ax);
        w_next[3] = w_next[2];
      end
      FUNC_TANK: begin
        w_next[0] = clamp_fs(f_ax);
        w_next[1] = w_next[0];
        w_next[2] = clamp_fs(t_ax);
        w_next[3] = w_next[2];
      end
      FUNC_MECANUM: begin
        mec_next  = 1'b1;
        w_next[0] = f_ax + s_ax + t_ax;
        w_next[1] = f_ax - s_ax + t_ax;
        w_next[2] = f_ax - s_ax - t_ax;
        w_next[3] = f_ax + s_ax - t_ax;
      end
      default: begin
        brake_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s2_mec   <= mec_next;
      s2_brake <= brake_next;
      for (int i = 0; i < LANES; i++) begin
        s2_w[i] <= w_next[i];
      end
    end
  end

  // Stage 3: wheel magnitudes and the largest of them.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      w_mag[i] = s2_w[i][SUM_W-1] ? MAG_W'(-s2_w[i]) : MAG_W'(s2_w[i]);
    end
    max01   = (w_mag[0] > w_mag[1]) ? w_mag[0] : w_mag[1];
    max23   = (w_mag[2] > w_mag[3]) ? w_mag[2] : w_mag[3];
    max_all = (max01 > max23) ? max01 : max23;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
      s3_scale <= s2_mec && (max_all > FS_MAG);
      s3_brake <= s2_brake;
      s3_max   <= max_all;
      for (int i = 0; i < LANES; i++) begin
        s3_mag[i]    <= w_mag[i];
        s3_neg[i]    <= s2_w[i][SUM_W-1];
        s3_direct[i] <= s2_w[i][WHEEL_W-1:0];
      end
    end
  end

  // Stage 4: numerator magnitude times full scale, divider entry.
  always_comb begin
    d0_next.valid   = s3_valid;
    d0_next.scale   = s3_scale;
    d0_next.brake   = s3_brake;
    d0_next.divisor = s3_max;
    for (int i = 0; i < LANES; i++) begin
      d0_next.lane[i].rem    = NUM_W'(s3_mag[i]) * FS_NUM;
      d0_next.lane[i].quo    = '0;
      d0_next.lane[i].neg    = s3_neg[i];
      d0_next.lane[i].direct = s3_direct[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_pipe[0].valid <= 1'b0;
    end else if (en) begin
      div_pipe[0] <= d0_next;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    dwm_div_stage #(
      .SHIFT(QUO_W - 1 - k)
    ) u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .din (div_pipe[k]),
      .dout(div_pipe[k+1])
    );
  end

  assign div_out = div_pipe[QUO_W];

  // Output stage: restore the sign of scaled wheels or pass them through.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      q_ext[i]      = WHEEL_W'(div_out.lane[i].quo);
      wheel_next[i] = div_out.lane[i].direct;
      if (div_out.scale) begin
        wheel_next[i] = div_out.lane[i].neg ? WHEEL_W'(-q_ext[i]) : q_ext[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid  <= div_out.valid;
      out_brake <= div_out.brake;
      for (int i = 0; i < LANES; i++) begin
        out_w[i] <= wheel_next[i];
      end
    end
  end

  assign m_tdata = {out_w[3], out_w[2], out_w[1], out_w[0]};
  assign m_tuser = out_brake;

  // Range flags used by the checks below.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      out_ok[i] = ($signed(out_w[i]) <= FS_WHEEL) && ($signed(out_w[i]) >= -FS_WHEEL);
      quo_ok[i] = div_out.lane[i].quo <= FS_QUO;
    end
  end

  `DWM_ASSERT_SAME(a_brake_zero, m_tvalid && m_tuser, m_tdata == '0, "brake with motion")
  `DWM_ASSERT_SAME(a_wheel_range, m_tvalid, &out_ok, "wheel beyond full scale")
  `DWM_ASSERT_SAME(a_quo_range, div_out.valid && div_out.scale, &quo_ok, "quotient too large")
  `DWM_ASSERT_NEXT(a_div_to_out, div_out.valid && en, m_tvalid, "result lost at output")

endmodule

>>> sv/dwm_div_stage.sv
// ---------------------------------------------------------------------------
// Drive wheel mixer divider stage
// One restoring division step for all four wheels, with its output register.
// ---------------------------------------------------------------------------
module dwm_div_stage
  import dwm_pkg::*;
#(
  parameter int unsigned SHIFT = QUO_W - 1
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  div_word_t din,
  output div_word_t dout
);

  logic [NUM_W-1:0] trial;
  div_word_t        d_next;

  // Divisor aligned to the quotient bit this stage decides.
  assign trial = NUM_W'(din.divisor) << SHIFT;

  // Subtract where the remainder allows and set the quotient bit.
  always_comb begin
    d_next = din;
    for (int i = 0; i < LANES; i++) begin
      if (din.lane[i].rem >= trial) begin
        d_next.lane[i].rem        = din.lane[i].rem - trial;
        d_next.lane[i].quo[SHIFT] = 1'b1;
      end
    end
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= d_next;
    end
  end

endmodule

>>> tb/tb_drive_wheel_mixer_core.sv
// ---------------------------------------------------------------------------
// Drive wheel mixer core testbench
// Sends drive commands in all four modes under a series of deadzone and gain
// settings, predicts the four wheel velocities and the brake flag of every
// accepted command, and checks each result word against the oldest
// prediction. Both streams idle in random bursts except in the last phase.
// ---------------------------------------------------------------------------
module tb_drive_wheel_mixer_core;
  import dwm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;

  // One drive command as the sender sees it.
  typedef struct {
    func_t             func;
    logic signed [7:0] fwd;
    logic signed [7:0] turn;
    logic signed [7:0] strafe;
  } drive_cmd_t;

  // One set of wheel velocities.
  typedef struct {
    logic signed [15:0] lf;
    logic signed [15:0] lb;
    logic signed [15:0] rf;
    logic signed [15:0] rb;
    logic               brake;
  } wheel_set_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [23:0]          s_tdata;   // forward_or_left, turn_or_right, strafe
  logic [1:0]           s_tuser;   // func
  logic                 m_tvalid;
  logic                 m_tready;
  logic [63:0]          m_tdata;   // left_front, left_back, right_front, right_back
  logic                 m_tuser;   // brake
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SENS_W-1:0]    cfg_data;

  // Commands waiting to be sent and velocities waiting to arrive.
  drive_cmd_t cmd_q[$];
  wheel_set_t wheel_q[$];
  drive_cmd_t cur_cmd;
  wheel_set_t want;

  // The testbench's own copy of the registers.
  logic [DZ_W-1:0]   dz_cfg;
  logic [SENS_W-1:0] gain_cfg;

  int errors;
  int src_gap;
  int sink_stall;
  int idle_cycles;
  bit calm;

  drive_wheel_mixer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock.
  always #5 clk = ~clk;

  // Deadzone, then gain and a floor shift into Q8.8.
  function automatic longint gain_axis(logic signed [7:0] axis);
    longint v;
    longint mag;
    v = longint'(axis);
    mag = (v < 0) ? -v : v;
    if (mag < longint'(dz_cfg)) return 0;
    return (v * longint'(gain_cfg)) >>> 4;
  endfunction

  function automatic longint clamp_full(longint v);
    if (v < -FULL_SCALE) return -FULL_SCALE;
    if (v > FULL_SCALE) return FULL_SCALE;
    return v;
  endfunction

  // Expected wheel velocities for one command under the current registers.
  function automatic wheel_set_t mix_wheels(drive_cmd_t c);
    wheel_set_t r;
    longint f, t, s, l, rt, peak;
    longint w[4];
    f = gain_axis(c.fwd);
    t = gain_axis(c.turn);
    s = gain_axis(c.strafe);
    w = '{0, 0, 0, 0};
    r.brake = 1'b0;
    case (c.func)
      FUNC_ARCADE: begin
        l = clamp_full(f + t);
        rt = clamp_full(f - t);
        w = '{l, l, rt, rt};
      end
      FUNC_TANK: begin
        l = clamp_full(f);
        rt = clamp_full(t);
        w = '{l, l, rt, rt};
      end
      FUNC_MECANUM: begin
        w = '{f + s + t, f - s + t, f - s - t, f + s - t};
        peak = 0;
        foreach (w[i]) if ((w[i] < 0 ? -w[i] : w[i]) > peak) peak = (w[i] < 0 ? -w[i] : w[i]);
        // Scale all four down together; division truncates toward zero.
        if (peak > FULL_SCALE) foreach (w[i]) w[i] = (w[i] * FULL_SCALE) / peak;
      end
      default: r.brake = 1'b1;
    endcase
    r.lf = w[0][15:0];
    r.lb = w[1][15:0];
    r.rf = w[2][15:0];
    r.rb = w[3][15:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic signed [15:0] exp_v,
                                 logic signed [15:0] got_v);
    $display("mismatch on %s at %0t: expected %0d, got %0d", field, $time, exp_v, got_v);
    errors++;
  endtask

  // Command driver: holds each word until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) wheel_q.push_back(mix_wheels(cur_cmd));
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          s_tdata <= {cur_cmd.strafe, cur_cmd.turn, cur_cmd.fwd};
          s_tuser <= cur_cmd.func;
          s_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 14);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (wheel_q.size() == 0) begin
          $display("result word at %0t with no command outstanding", $time);
          errors++;
        end else begin
          want = wheel_q.pop_front();
          if (m_tdata[15:0] !== want.lf) report_mismatch("left_front", want.lf, m_tdata[15:0]);
          if (m_tdata[31:16] !== want.lb) report_mismatch("left_back", want.lb, m_tdata[31:16]);
          if (m_tdata[47:32] !== want.rf)
            report_mismatch("right_front", want.rf, m_tdata[47:32]);
          if (m_tdata[63:48] !== want.rb) report_mismatch("right_back", want.rb, m_tdata[63:48]);
          if (m_tuser !== want.brake) report_mismatch("brake", want.brake, m_tuser);
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no word moves anywhere.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Write one register and mirror it once the word is taken.
  task automatic write_reg(cfg_reg_t idx, logic [SENS_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_DEADZONE) dz_cfg = value[DZ_W-1:0];
    else gain_cfg = value;
  endtask

  // Wait until every command has been sent and answered, then let it settle.
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_q.size() != 0 || s_tvalid || wheel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic drive_cmd_t make_cmd(func_t fn, int f, int t, int s);
    drive_cmd_t c;
    c.func = fn;
    c.fwd = f[7:0];
    c.turn = t[7:0];
    c.strafe = s[7:0];
    return c;
  endfunction

  // Random axis: mostly anything, sometimes at the deadzone edge or the extremes.
  function automatic logic signed [7:0] pick_axis();
    int d;
    case ($urandom_range(0, 7))
      0: begin
        d = int'(dz_cfg) + int'($urandom_range(0, 2)) - 1;
        return 8'($urandom_range(0, 1) ? -d : d);
      end
      1: begin
        case ($urandom_range(0, 3))
          0: return 8'sd127;
          1: return -8'sd128;
          2: return -8'sd127;
          default: return 8'sd0;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_random(int count);
    drive_cmd_t c;
    repeat (count) begin
      c.func = func_t'($urandom_range(0, 3));
      c.fwd = pick_axis();
      c.turn = pick_axis();
      c.strafe = pick_axis();
      cmd_q.push_back(c);
    end
  endtask

  // Extremes in every mode, deadzone edges and the single-axis cases.
  task automatic add_directed();
    int d;
    d = int'(dz_cfg);
    cmd_q.push_back(make_cmd(FUNC_ARCADE, 127, 127, 127));
    cmd_q.push_back(make_cmd(FUNC_ARCADE, -128, -128, -128));
    cmd_q.push_back(make_cmd(FUNC_ARCADE, 127, -128, 0));
    cmd_q.push_back(make_cmd(FUNC_ARCADE, 0, 0, 0));
    cmd_q.push_back(make_cmd(FUNC_ARCADE, d - 1, d, -d));
    cmd_q.push_back(make_cmd(FUNC_ARCADE, -(d - 1), -d, d));
    cmd_q.push_back(make_cmd(FUNC_TANK, 127, -128, 55));
    cmd_q.push_back(make_cmd(FUNC_TANK, -128, 127, -1));
    cmd_q.push_back(make_cmd(FUNC_TANK, d, d - 1, 0));
    cmd_q.push_back(make_cmd(FUNC_MECANUM, 127, 127, 127));
    cmd_q.push_back(make_cmd(FUNC_MECANUM, -128, -128, -128));
    cmd_q.push_back(make_cmd(FUNC_MECANUM, 127, 0, 0));
    cmd_q.push_back(make_cmd(FUNC_MECANUM, 0, 127, 0));
    cmd_q.push_back(make_cmd(FUNC_MECANUM, 0, 0, -128));
    cmd_q.push_back(make_cmd(FUNC_MECANUM, 100, -100, 50));
    cmd_q.push_back(make_cmd(FUNC_MECANUM, d, -d, d - 1));
    cmd_q.push_back(make_cmd(FUNC_STOP, 127, 127, 127));
    cmd_q.push_back(make_cmd(FUNC_STOP, -128, -128, -128));
    cmd_q.push_back(make_cmd(FUNC_STOP, 0, 0, 0));
  endtask

  // Phase sequence: reset values, then extreme and random register settings.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEADZONE;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    calm = 1'b0;
    dz_cfg = DZ_RESET;
    gain_cfg = SENS_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add_directed();
    wait_idle();

    write_reg(REG_DEADZONE, 16'd0);
    write_reg(REG_SENSITIVITY, 16'hFFFF);
    add_directed();
    add_random(250);
    wait_idle();

    write_reg(REG_DEADZONE, 16'd127);
    write_reg(REG_SENSITIVITY, 16'd0);
    add_directed();
    add_random(100);
    wait_idle();

    write_reg(REG_DEADZONE, 16'd1);
    write_reg(REG_SENSITIVITY, 16'd16384);
    add_directed();
    add_random(250);
    wait_idle();

    // Random settings; upper data bits of the deadzone word are exercised too.
    repeat (5) begin
      write_reg(REG_DEADZONE, SENS_W'($urandom_range(0, 16'hFFFF)));
      write_reg(REG_SENSITIVITY, SENS_W'($urandom_range(0, 16'hFFFF)));
      add_random(200);
      wait_idle();
    end

    // Last phase runs at full rate with no idling.
    calm = 1'b1;
    write_reg(REG_DEADZONE, 16'd5);
    write_reg(REG_SENSITIVITY, 16'd4096);
    add_random(250);
    wait_idle();

    if (errors == 0 && wheel_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
